// File: design/tfn_pkg.sv
package tfn_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int NORMAL_WIDTH_DEF = 16;

  // the largest scaled cross magnitude sits in [2^29, 2^30)
  localparam int MAG_BITS  = 30;
  localparam int SUM_BITS  = 2 * MAG_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = SUM_BITS + 1;

  typedef struct packed {
    logic [MAG_BITS-1:0] mag_x;
    logic [MAG_BITS-1:0] mag_y;
    logic [MAG_BITS-1:0] mag_z;
    logic                neg_x;
    logic                neg_y;
    logic                neg_z;
    logic                degenerate;
  } side_t;

endpackage

// File: design/tfn_tri_if.sv
interface tfn_tri_if #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

// File: design/tfn_norm_if.sv
interface tfn_norm_if #(
  parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] norm_x;
  logic signed [NORMAL_WIDTH-1:0] norm_y;
  logic signed [NORMAL_WIDTH-1:0] norm_z;
  logic                           degenerate;

  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// File: design/tfn_isqrt.sv
module tfn_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tfn_pkg::SUM_BITS-1:0]  radicand,
  output logic [tfn_pkg::ROOT_BITS-1:0] root
);
  import tfn_pkg::*;

  localparam int SQ = ROOT_BITS;

  logic [REM_BITS-1:0] xs [SQ];
  logic [REM_BITS-1:0] rs [SQ];

  // one result bit per stage, test bit walks down two places each stage
  for (genvar k = 0; k < SQ; k++) begin : g_step
    localparam logic [REM_BITS-1:0] BIT = REM_BITS'(1) << (2 * (SQ - 1 - k));
    logic [REM_BITS-1:0] xin;
    logic [REM_BITS-1:0] rin;
    logic [REM_BITS-1:0] trial;

    if (k == 0) begin : g_first
      assign xin = REM_BITS'(radicand);
      assign rin = '0;
    end else begin : g_next
      assign xin = xs[k-1];
      assign rin = rs[k-1];
    end

    assign trial = rin + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (xin >= trial) begin
          xs[k] <= xin - trial;
          rs[k] <= (rin >> 1) + BIT;
        end else begin
          xs[k] <= xin;
          rs[k] <= rin >> 1;
        end
      end
    end
  end

  assign root = rs[SQ-1][ROOT_BITS-1:0];

endmodule

// File: design/tfn_divide.sv
module tfn_divide #(
  parameter int FRAC_BITS = tfn_pkg::NORMAL_WIDTH_DEF - 2
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [tfn_pkg::MAG_BITS+FRAC_BITS:0]     numer,
  input  logic [tfn_pkg::ROOT_BITS-1:0]            divisor,
  output logic [FRAC_BITS:0]                       quot
);
  import tfn_pkg::*;

  localparam int DV = FRAC_BITS + 1;
  localparam int DW = ROOT_BITS + FRAC_BITS + 1;

  logic [DW-1:0]        rem [DV];
  logic [ROOT_BITS-1:0] dvs [DV];
  logic [FRAC_BITS:0]   qb  [DV];

  // restoring division, one quotient bit per stage, top bit first
  for (genvar j = 0; j < DV; j++) begin : g_step
    localparam int K = FRAC_BITS - j;
    localparam logic [FRAC_BITS:0] QBIT = (FRAC_BITS + 1)'(1) << K;
    logic [DW-1:0]        rin;
    logic [ROOT_BITS-1:0] din;
    logic [FRAC_BITS:0]   qin;
    logic [DW-1:0]        sub;

    if (j == 0) begin : g_first
      assign rin = DW'(numer);
      assign din = divisor;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[j-1];
      assign din = dvs[j-1];
      assign qin = qb[j-1];
    end

    assign sub = DW'(din) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dvs[j] <= din;
        if (rin >= sub) begin
          rem[j] <= rin - sub;
          qb[j]  <= qin | QBIT;
        end else begin
          rem[j] <= rin;
          qb[j]  <= qin;
        end
      end
    end
  end

  assign quot = qb[DV-1];

endmodule

// File: design/triangle_face_normal_unit.sv
// Channel    Dir  Interface    Payload
// tri_in     in   tfn_tri_if   a_x a_y a_z b_x b_y b_z c_x c_y c_z (signed Q8.8)
// norm_out   out  tfn_norm_if  norm_x norm_y norm_z (signed Q1.F), degenerate
//
// One triangle per cycle while the output is not stalled.
// The pipeline runs through the 31-stage square root and the one-bit-per-stage divider.
// Reset clears only the stage valid bits; the data path has no reset.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module triangle_face_normal_unit #(
  parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tfn_tri_if.sink   tri_in,
  tfn_norm_if.source norm_out
);
  import tfn_pkg::*;

  localparam int EW   = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1;
  localparam int PRE  = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int PW   = 2 * EW;
  localparam int MW   = PW;
  localparam int SHW  = $clog2(MW + 1);
  localparam int FRAC = NORMAL_WIDTH - 2;
  localparam int DV   = FRAC + 1;
  localparam int SQ   = ROOT_BITS;
  localparam int NUMW = MAG_BITS + FRAC + 1;
  localparam int LAT  = 8 + SQ + 1 + DV + 1;

  logic           adv;
  logic [LAT-1:0] vld;

  assign adv          = !vld[LAT-1] || norm_out.ready;
  assign tri_in.ready = adv;
  assign norm_out.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], tri_in.valid};
    end
  end

  // stage 1: edges
  logic signed [COORD_WIDTH-1:0] vin [9];
  logic [EW-1:0] e_next [6];
  logic [EW-1:0] e [6];

  assign vin[0] = tri_in.a_x;
  assign vin[1] = tri_in.a_y;
  assign vin[2] = tri_in.a_z;
  assign vin[3] = tri_in.b_x;
  assign vin[4] = tri_in.b_y;
  assign vin[5] = tri_in.b_z;
  assign vin[6] = tri_in.c_x;
  assign vin[7] = tri_in.c_y;
  assign vin[8] = tri_in.c_z;

  always_comb begin
    logic [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0] dm;
    logic [COORD_WIDTH:0] sh;
    logic [COORD_WIDTH:0] ev;
    for (int i = 0; i < 6; i++) begin
      d  = {vin[3+i][COORD_WIDTH-1], vin[3+i]}
         - {vin[(i < 3) ? i : i - 3][COORD_WIDTH-1], vin[(i < 3) ? i : i - 3]};
      dm = d[COORD_WIDTH] ? (~d + 1'b1) : d;
      // truncate magnitude toward zero on wide coordinates
      sh = dm >> PRE;
      ev = d[COORD_WIDTH] ? (~sh + 1'b1) : sh;
      e_next[i] = ev[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        e[i] <= e_next[i];
      end
    end
  end

  // stage 2: products; e[0..2] = b - a, e[3..5] = c - a
  logic signed [PW-1:0] prod [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0] <= $signed(e[1]) * $signed(e[5]);
      prod[1] <= $signed(e[2]) * $signed(e[4]);
      prod[2] <= $signed(e[2]) * $signed(e[3]);
      prod[3] <= $signed(e[0]) * $signed(e[5]);
      prod[4] <= $signed(e[0]) * $signed(e[4]);
      prod[5] <= $signed(e[1]) * $signed(e[3]);
    end
  end

  // stage 3: cross product as sign and magnitude
  logic [MW-1:0] mag3 [3];
  logic [2:0]    neg3;
  logic          deg3;
  logic [MW-1:0] mag3_next [3];
  logic [2:0]    neg3_next;
  logic          deg3_next;

  always_comb begin
    logic [PW:0] cr;
    logic [PW:0] m;
    deg3_next = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cr = {prod[2*i][PW-1], prod[2*i]} - {prod[2*i+1][PW-1], prod[2*i+1]};
      m  = cr[PW] ? (~cr + 1'b1) : cr;
      mag3_next[i] = m[MW-1:0];
      neg3_next[i] = cr[PW];
      if (cr != '0) begin
        deg3_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag3 <= mag3_next;
      neg3 <= neg3_next;
      deg3 <= deg3_next;
    end
  end

  // stage 4: largest magnitude
  logic [MW-1:0] mag4 [3];
  logic [MW-1:0] mx4;
  logic [2:0]    neg4;
  logic          deg4;
  logic [MW-1:0] mx4_next;

  always_comb begin
    mx4_next = mag3[0];
    if (mag3[1] > mx4_next) begin
      mx4_next = mag3[1];
    end
    if (mag3[2] > mx4_next) begin
      mx4_next = mag3[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag4 <= mag3;
      mx4  <= mx4_next;
      neg4 <= neg3;
      deg4 <= deg3;
    end
  end

  // stage 5: leading one of the largest magnitude
  logic [MW-1:0]  mag5 [3];
  logic [SHW-1:0] sh5;
  logic [2:0]     neg5;
  logic           deg5;
  logic [SHW-1:0] pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < MW; i++) begin
      if (mx4[i]) begin
        pos = SHW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag5 <= mag4;
      sh5  <= pos + 1'b1;
      neg5 <= neg4;
      deg5 <= deg4;
    end
  end

  // stage 6: common shift puts the largest in [2^29, 2^30)
  side_t side6;
  logic [MW+MAG_BITS-1:0] t6 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t6[i] = {mag5[i], MAG_BITS'(0)} >> sh5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side6.mag_x      <= t6[0][MAG_BITS-1:0];
      side6.mag_y      <= t6[1][MAG_BITS-1:0];
      side6.mag_z      <= t6[2][MAG_BITS-1:0];
      side6.neg_x      <= neg5[0];
      side6.neg_y      <= neg5[1];
      side6.neg_z      <= neg5[2];
      side6.degenerate <= deg5;
    end
  end

  // stage 7: squares; stage 8: sum of squares
  side_t                   side7;
  side_t                   side8;
  logic [2*MAG_BITS-1:0]   sq7 [3];
  logic [SUM_BITS-1:0]     sum8;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq7[0] <= side6.mag_x * side6.mag_x;
      sq7[1] <= side6.mag_y * side6.mag_y;
      sq7[2] <= side6.mag_z * side6.mag_z;
      side7  <= side6;
      sum8   <= SUM_BITS'(sq7[0]) + SUM_BITS'(sq7[1]) + SUM_BITS'(sq7[2]);
      side8  <= side7;
    end
  end

  // square root, side data delayed alongside
  logic [ROOT_BITS-1:0] root;
  side_t                sdq [SQ];

  tfn_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sum8),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sdq[0] <= side8;
      for (int k = 1; k < SQ; k++) begin
        sdq[k] <= sdq[k-1];
      end
    end
  end

  // numerators with half the length added for rounding
  side_t                side_n;
  logic [ROOT_BITS-1:0] len_n;
  logic [NUMW-1:0]      numer_n [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      len_n      <= root;
      numer_n[0] <= (NUMW'(sdq[SQ-1].mag_x) << FRAC) + NUMW'(root >> 1);
      numer_n[1] <= (NUMW'(sdq[SQ-1].mag_y) << FRAC) + NUMW'(root >> 1);
      numer_n[2] <= (NUMW'(sdq[SQ-1].mag_z) << FRAC) + NUMW'(root >> 1);
      side_n     <= sdq[SQ-1];
    end
  end

  logic [FRAC:0] quot [3];
  side_t         sdv [DV];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tfn_divide #(
      .FRAC_BITS (FRAC)
    ) u_divide (
      .clk     (clk),
      .en      (adv),
      .numer   (numer_n[i]),
      .divisor (len_n),
      .quot    (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdv[0] <= side_n;
      for (int k = 1; k < DV; k++) begin
        sdv[k] <= sdv[k-1];
      end
    end
  end

  // output stage: restore signs, zero a degenerate normal
  logic [NORMAL_WIDTH-1:0] qv [3];
  logic [2:0]              negs;

  assign negs = {sdv[DV-1].neg_z, sdv[DV-1].neg_y, sdv[DV-1].neg_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = negs[i] ? (~NORMAL_WIDTH'(quot[i]) + 1'b1) : NORMAL_WIDTH'(quot[i]);
      if (sdv[DV-1].degenerate) begin
        qv[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_out.norm_x     <= qv[0];
      norm_out.norm_y     <= qv[1];
      norm_out.norm_z     <= qv[2];
      norm_out.degenerate <= sdv[DV-1].degenerate;
    end
  end

  localparam logic signed [NORMAL_WIDTH-1:0] ONE = NORMAL_WIDTH'(1) << FRAC;

  a_deg_zero_cross : assert property (@(posedge clk) disable iff (rst)
    vld[2] && deg3 |-> mag3[0] == '0 && mag3[1] == '0 && mag3[2] == '0)
    else $error("degenerate flag with nonzero cross product");

  a_scaled_top : assert property (@(posedge clk) disable iff (rst)
    vld[5] && !side6.degenerate
      |-> side6.mag_x[MAG_BITS-1] || side6.mag_y[MAG_BITS-1] || side6.mag_z[MAG_BITS-1])
    else $error("block scaling missed the top bit");

  a_len_range : assert property (@(posedge clk) disable iff (rst)
    vld[8+SQ] && !side_n.degenerate |-> len_n[ROOT_BITS-1:MAG_BITS-1] != '0)
    else $error("length below scaled range");

  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    norm_out.valid |-> norm_out.norm_x <= ONE && norm_out.norm_x >= -ONE
      && norm_out.norm_y <= ONE && norm_out.norm_y >= -ONE
      && norm_out.norm_z <= ONE && norm_out.norm_z >= -ONE)
    else $error("normal component out of unit range");

  a_deg_out : assert property (@(posedge clk) disable iff (rst)
    norm_out.valid && norm_out.degenerate
      |-> norm_out.norm_x == '0 && norm_out.norm_y == '0 && norm_out.norm_z == '0)
    else $error("degenerate result with nonzero normal");

endmodule

// File: tb/triangle_face_normal_unit_tb.sv
`timescale 1ns / 1ps

module triangle_face_normal_unit_tb;
  import tfn_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int NW = NORMAL_WIDTH_DEF;
  localparam int FRAC = NW - 2;
  localparam int LATENCY = NW + 40;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
    logic                 degenerate;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
  tfn_norm_if #(.NORMAL_WIDTH(NW)) norm_ch ();

  triangle_face_normal_unit #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) DUT (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_ch.sink),
    .norm_out(norm_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  normal_t normals_due[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int degenerate_seen = 0;
  int idle_cycles = 0;
  bit sink_stalls = 1'b1;

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit normal of triangle (a, b, c), cross product (b-a) x (c-a).
  function automatic normal_t face_normal(logic signed [CW-1:0] p[9]);
    longint e1[3], e2[3], cr[3];
    longint unsigned mg[3], mx, total, len, q;
    normal_t n;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(p[3+i]) - longint'(p[i]);
      e2[i] = longint'(p[6+i]) - longint'(p[i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    n = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (mg[i] > mx) mx = mg[i];
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    total = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    len = isqrt(total);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << FRAC) + (len >> 1)) / len;
      if (cr[i] < 0) q = -q;
      case (i)
        0: n.x = q[NW-1:0];
        1: n.y = q[NW-1:0];
        default: n.z = q[NW-1:0];
      endcase
    end
    return n;
  endfunction

  // Mostly no gap, some short ones, and a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold valid high until the transfer; the caller drops it when idling.
  task automatic send_triangle(logic signed [CW-1:0] p[9]);
    tri_ch.valid <= 1'b1;
    tri_ch.a_x <= p[0];
    tri_ch.a_y <= p[1];
    tri_ch.a_z <= p[2];
    tri_ch.b_x <= p[3];
    tri_ch.b_y <= p[4];
    tri_ch.b_z <= p[5];
    tri_ch.c_x <= p[6];
    tri_ch.c_y <= p[7];
    tri_ch.c_z <= p[8];
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    normals_due.insert(normals_due.size(), face_normal(p));
    sent++;
  endtask

  task automatic idle_input();
    tri_ch.valid <= 1'b0;
  endtask

  task automatic send_with_gap(logic signed [CW-1:0] p[9]);
    int g;
    g = gap_len();
    if (g > 0) begin
      idle_input();
      repeat (g) @(posedge clk);
    end
    send_triangle(p);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      norm_ch.ready <= 1'b0;
    end else begin
      norm_ch.ready <= sink_stalls ? ($urandom_range(0, 99) >= 30) : 1'b1;
    end
  end

  always @(posedge clk) begin
    normal_t want;
    if (!rst && norm_ch.valid && norm_ch.ready) begin
      received++;
      if (norm_ch.degenerate) degenerate_seen++;
      if (normals_due.size() == 0) begin
        $error("normal transfer with none expected");
        errors++;
      end else begin
        want = normals_due.pop_front();
        if (norm_ch.norm_x !== want.x) begin
          $error("norm_x expected %0d actual %0d", want.x, norm_ch.norm_x);
          errors++;
        end
        if (norm_ch.norm_y !== want.y) begin
          $error("norm_y expected %0d actual %0d", want.y, norm_ch.norm_y);
          errors++;
        end
        if (norm_ch.norm_z !== want.z) begin
          $error("norm_z expected %0d actual %0d", want.z, norm_ch.norm_z);
          errors++;
        end
        if (norm_ch.degenerate !== want.degenerate) begin
          $error("degenerate expected %0b actual %0b", want.degenerate,
                 norm_ch.degenerate);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((tri_ch.valid && tri_ch.ready) || (norm_ch.valid && norm_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [CW-1:0] any_coord();
    return CW'($urandom);
  endfunction

  task automatic test_extremes();
    logic signed [CW-1:0] p[9];
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    // largest edges, each axis orientation
    p = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
    send_triangle(p);
    p = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
    send_triangle(p);
    p = '{mn, mn, mn, mn, mx, mn, mn, mn, mx};
    send_triangle(p);
    p = '{mn, mn, mn, mn, mn, mx, mx, mn, mn};
    send_triangle(p);
    p = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
    send_triangle(p);
    // smallest non-zero cross product
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
    send_triangle(p);
    // diagonal: equal components, rounding at every axis
    p = '{0, 0, 0, 256, -256, 0, 0, 256, -256};
    send_triangle(p);
    p = '{-1, -1, -1, -1, -1, -1, 5, 7, 9};
    send_triangle(p);
    // one tiny component next to huge ones
    p = '{0, 0, 0, mx, 1, 0, 0, mx, 1};
    send_triangle(p);
    p = '{mx, mx, mx, mx, mx, mx, mn, mn, mn};
    send_triangle(p);
  endtask

  task automatic test_degenerate();
    logic signed [CW-1:0] p[9];
    int k;
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(p);
    p = '{-32768, 32767, 5, -32768, 32767, 5, -32768, 32767, 5};
    send_triangle(p);
    // collinear: c = a + 2*(b-a)
    p = '{10, 20, 30, 11, 22, 33, 12, 24, 36};
    send_triangle(p);
    p = '{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767};
    send_triangle(p);
    for (int i = 0; i < 40; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[j] = CW'($urandom_range(0, 8000)) - 16'sd4000;
        p[3+j] = CW'($urandom_range(0, 200)) - 16'sd100;
      end
      k = int'($urandom_range(0, 6)) - 3;
      for (int j = 0; j < 3; j++) begin
        p[6+j] = p[j] + k * p[3+j];
        p[3+j] = p[j] + p[3+j];
      end
      send_with_gap(p);
    end
  endtask

  task automatic test_random(int count);
    logic signed [CW-1:0] p[9];
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      for (int j = 0; j < 9; j++) begin
        if (r < 5) p[j] = any_coord();
        else if (r < 8) p[j] = CW'($urandom_range(0, 64)) - 16'sd32;
        else p[j] = $urandom_range(0, 1) ? 16'sh7fff - CW'($urandom_range(0, 3))
                                          : 16'sh8000 + CW'($urandom_range(0, 3));
      end
      if (i % 200 < 30) send_triangle(p);
      else send_with_gap(p);
    end
  endtask

  task automatic test_drain_pause();
    idle_input();
    while (normals_due.size() != 0) @(posedge clk);
    test_random(10);
  endtask

  task automatic test_no_sink_stall();
    sink_stalls = 1'b0;
    test_random(100);
    sink_stalls = 1'b1;
  endtask

  initial begin
    tri_ch.valid = 1'b0;
    tri_ch.a_x = '0;
    tri_ch.a_y = '0;
    tri_ch.a_z = '0;
    tri_ch.b_x = '0;
    tri_ch.b_y = '0;
    tri_ch.b_z = '0;
    tri_ch.c_x = '0;
    tri_ch.c_y = '0;
    tri_ch.c_z = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_random(500);
    test_drain_pause();
    test_no_sink_stall();
    test_random(190);
    idle_input();
    while (normals_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d triangles, checked %0d normals (%0d degenerate).",
             sent, received, degenerate_seen);
    $display("Covered extreme coordinates, collinear and random triangles, stalls.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: triangle_face_normal_unit.f
design/tfn_pkg.sv
design/tfn_tri_if.sv
design/tfn_norm_if.sv
design/tfn_isqrt.sv
design/tfn_divide.sv
design/triangle_face_normal_unit.sv
tb/triangle_face_normal_unit_tb.sv
